// File: sv/lsp_pkg.sv
package lsp_pkg;

    localparam int ADDR_W  = 16;
    localparam int MIX_W   = 24;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int DIV_STEPS = 17;

    localparam logic [12:0] UNITY_GAIN = 13'd4096;
    localparam logic [12:0] FRAME_MAX  = 13'd4096;
    localparam logic [MIX_W-1:0] MIX_MAX = 24'h7FFFFF;
    localparam logic [MIX_W-1:0] MIX_MIN = 24'h800000;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_TICK  = 1'b1
    } req_type_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_LOOP_START   = 3'd0,
        REG_LOOP_END     = 3'd1,
        REG_AMOUNT       = 3'd2,
        REG_FRAME_LENGTH = 3'd3,
        REG_LEFT_ENABLE  = 3'd4,
        REG_RIGHT_ENABLE = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ADV_IDLE,
        ADV_ALIGN,
        ADV_SETUP,
        ADV_DIV,
        ADV_DONE
    } adv_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] loop_start;
        logic [ADDR_W-1:0] loop_end;
        logic [12:0]       amount;
        logic [12:0]       frame_length;
        logic              left_enable;
        logic              right_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        loop_start:   16'd0,
        loop_end:     16'd0,
        amount:       13'd4096,
        frame_length: 13'd256,
        left_enable:  1'b1,
        right_enable: 1'b1
    };

    typedef struct packed {
        logic              playing;
        logic              fwd;
        logic [ADDR_W-1:0] range;
    } geom_t;

    // frame base and loop offset of the tick being accepted
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] off;
    } pos_t;

    function automatic geom_t loop_geom(input cfg_t c);
        geom_t gm;
        gm.playing = c.loop_start != c.loop_end;
        gm.fwd     = c.loop_start < c.loop_end;
        gm.range   = gm.fwd ? c.loop_end - c.loop_start : c.loop_start - c.loop_end;
        return gm;
    endfunction

endpackage

// File: sv/loop_sample_player.sv
// Tick path: stage 1, sample read (stage 2), gain register, result registered on m_*.
// Throughput: one item (write or tick) per cycle unless m_ready stalls; a playing tick
// that closes a frame holds s_ready and cfg_ready low while the frame base is advanced
// by a 17-step restoring remainder unit, or in reverse without wrap by a plain step back.
// Reset (aresetn low, synchronous): registers to defaults, frame state and pipeline cleared;
// sample memories keep their contents. SAMPLE_DEPTH must be a power of two (not enforced).
module loop_sample_player import lsp_pkg::*; #(
    parameter int SAMPLE_DEPTH = 65536,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  logic [ADDR_W-1:0]        s_write_addr,
    input  logic signed [15:0]       s_write_left,
    input  logic signed [15:0]       s_write_right,
    input  logic signed [MIX_W-1:0]  s_mix_left_in,
    input  logic signed [MIX_W-1:0]  s_mix_right_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [MIX_W-1:0]  m_mix_left_out,
    output logic signed [MIX_W-1:0]  m_mix_right_out,
    output logic [ADDR_W-1:0]        m_read_position,
    output logic                     m_playing,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(SAMPLE_DEPTH);

    cfg_t cfg_reg, cfg_next;
    geom_t geo;

    logic s_acc;
    logic tick_fire;
    logic adv_busy;
    pos_t cur;
    logic en1, en2;
    logic mix_ready;

    logic signed [SAMPLE_BITS-1:0] wl0, wr0;

    logic                          v1_reg;
    logic                          tick1_reg;
    logic [AW-1:0]                 waddr1_reg;
    logic signed [SAMPLE_BITS-1:0] wl1_reg, wr1_reg;
    logic signed [MIX_W-1:0]       ml1_reg, mr1_reg;
    logic [ADDR_W-1:0]             base1_reg, off1_reg;
    logic                          play1_reg;

    logic [16:0]       sum17, dif17;
    logic [ADDR_W-1:0] idx;
    logic [AW-1:0]     raddr;
    logic [ADDR_W-1:0] pos1;

    logic                    v2_reg;
    logic signed [MIX_W-1:0] ml2_reg, mr2_reg;
    logic [ADDR_W-1:0]       pos2_reg;
    logic                    play2_reg;

    logic                   ram_we, ram_re;
    logic [SAMPLE_BITS-1:0] rd_left, rd_right;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LOOP_START:   cfg_next.loop_start   = cfg_data;
                REG_LOOP_END:     cfg_next.loop_end     = cfg_data;
                REG_AMOUNT:       cfg_next.amount       = cfg_data[12:0];
                REG_FRAME_LENGTH: cfg_next.frame_length = cfg_data[12:0];
                REG_LEFT_ENABLE:  cfg_next.left_enable  = cfg_data[0];
                REG_RIGHT_ENABLE: cfg_next.right_enable = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign geo       = loop_geom(cfg_reg);
    assign cfg_ready = !adv_busy;

    // pipeline enables
    assign en2       = !v2_reg || mix_ready;
    assign en1       = !v1_reg || en2;
    assign s_ready   = en1 && !adv_busy;
    assign s_acc     = s_valid && s_ready;
    assign tick_fire = s_acc && (s_req_type == REQ_TICK);

    lsp_pos u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .tick_fire (tick_fire),
        .cur       (cur),
        .busy      (adv_busy)
    );

    if (SAMPLE_BITS >= 16) begin : g_widen
        assign wl0 = SAMPLE_BITS'(s_write_left) <<< (SAMPLE_BITS - 16);
        assign wr0 = SAMPLE_BITS'(s_write_right) <<< (SAMPLE_BITS - 16);
    end else begin : g_narrow
        assign wl0 = SAMPLE_BITS'(s_write_left >>> (16 - SAMPLE_BITS));
        assign wr0 = SAMPLE_BITS'(s_write_right >>> (16 - SAMPLE_BITS));
    end

    // stage 1: transaction registered, read address formed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            tick1_reg  <= s_req_type == REQ_TICK;
            waddr1_reg <= AW'(s_write_addr);
            wl1_reg    <= wl0;
            wr1_reg    <= wr0;
            ml1_reg    <= s_mix_left_in;
            mr1_reg    <= s_mix_right_in;
            base1_reg  <= cur.base;
            off1_reg   <= cur.off;
            play1_reg  <= geo.playing;
        end
    end

    always_comb begin
        sum17 = {1'b0, base1_reg} + {1'b0, off1_reg};
        dif17 = {1'b0, base1_reg} - {1'b0, off1_reg};
        if (geo.fwd) begin
            idx = (sum17 >= {1'b0, cfg_reg.loop_end}) ? 16'(sum17 - {1'b0, geo.range})
                                                      : sum17[15:0];
        end else begin
            // wrap up by the loop length when below the loop end
            idx = (dif17[16] || dif17[15:0] < cfg_reg.loop_end) ? dif17[15:0] + geo.range
                                                                 : dif17[15:0];
        end
        raddr = AW'(idx);
        pos1  = play1_reg ? 16'(raddr) : '0;
    end

    // writes and reads both land on the stage-1 to stage-2 move, keeping item order
    assign ram_we = en2 && v1_reg && !tick1_reg;
    assign ram_re = en2 && v1_reg && tick1_reg;

    lsp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SAMPLE_DEPTH)) u_ram_left (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr1_reg),
        .wdata (wl1_reg),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rd_left)
    );

    lsp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SAMPLE_DEPTH)) u_ram_right (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr1_reg),
        .wdata (wr1_reg),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rd_right)
    );

    // stage 2: sample read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg && tick1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            ml2_reg   <= ml1_reg;
            mr2_reg   <= mr1_reg;
            pos2_reg  <= pos1;
            play2_reg <= play1_reg;
        end
    end

    lsp_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (v2_reg),
        .in_ready        (mix_ready),
        .in_mix_left     (ml2_reg),
        .in_mix_right    (mr2_reg),
        .in_pos          (pos2_reg),
        .in_playing      (play2_reg),
        .in_left         ($signed(rd_left)),
        .in_right        ($signed(rd_right)),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mix_left_out  (m_mix_left_out),
        .m_mix_right_out (m_mix_right_out),
        .m_read_position (m_read_position),
        .m_playing       (m_playing)
    );

endmodule

// File: sv/lsp_ram.sv
module lsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lsp_pos.sv
module lsp_pos import lsp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic tick_fire,
    output pos_t cur,
    output logic busy
);

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [11:0]       count_reg, count_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;
    adv_state_t        state_reg, state_next;
    logic [16:0]       num_reg, num_next;
    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [4:0]        step_reg, step_next;

    geom_t             geo;
    logic [12:0]       fl;
    logic              first;
    logic              frame_end;
    logic [ADDR_W-1:0] off_raw;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] base_eff;
    logic [ADDR_W-1:0] rel;
    logic [16:0]       fwd_num;
    logic [16:0]       rem_sh;

    function automatic logic outside(input logic [ADDR_W-1:0] b, input cfg_t c,
                                     input logic fwd);
        return fwd ? (b < c.loop_start || b >= c.loop_end)
                   : (b < c.loop_end || b > c.loop_start);
    endfunction

    always_comb begin
        geo       = loop_geom(cfg);
        fl        = (cfg.frame_length == '0) ? 13'd1 :
                    (cfg.frame_length > FRAME_MAX) ? FRAME_MAX : cfg.frame_length;
        first     = count_reg == '0;
        off_raw   = first ? '0 : offset_reg;
        off       = (off_raw >= geo.range) ? '0 : off_raw;
        base_eff  = (first && outside(base_reg, cfg, geo.fwd)) ? cfg.loop_start : base_reg;
        frame_end = ({1'b0, count_reg} + 13'd1) >= fl;
        rel       = base_reg - cfg.loop_end;
        fwd_num   = {1'b0, base_reg} - {1'b0, cfg.loop_start} + {4'b0, fl};
        rem_sh    = {rem_reg, num_reg[16]};
    end

    assign cur.base = base_eff;
    assign cur.off  = off;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ADV_IDLE: begin
                if (tick_fire && frame_end && geo.playing) begin
                    state_next = ADV_ALIGN;
                end
            end
            ADV_ALIGN: state_next = ADV_SETUP;
            ADV_SETUP: begin
                if (!geo.fwd && rel >= 16'(fl)) begin
                    state_next = ADV_IDLE;
                end else begin
                    state_next = ADV_DIV;
                end
            end
            ADV_DIV: begin
                if (step_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ADV_DONE;
                end
            end
            ADV_DONE: state_next = ADV_IDLE;
            default:  state_next = ADV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy = state_reg != ADV_IDLE;
    end

    // frame state and base advance datapath
    always_comb begin
        base_next   = base_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        case (state_reg)
            ADV_IDLE: begin
                if (tick_fire) begin
                    count_next = frame_end ? '0 : count_reg + 12'd1;
                    if (geo.playing) begin
                        offset_next = (off == geo.range - 16'd1) ? '0 : off + 16'd1;
                        base_next   = base_eff;
                    end else begin
                        offset_next = '0;
                    end
                end
            end
            ADV_ALIGN: begin
                if (outside(base_reg, cfg, geo.fwd)) begin
                    base_next = cfg.loop_start;
                end
            end
            ADV_SETUP: begin
                rem_next  = '0;
                step_next = '0;
                if (geo.fwd) begin
                    num_next = fwd_num;
                end else if (rel >= 16'(fl)) begin
                    // no wrap below the loop end: step straight back
                    base_next = base_reg - 16'(fl);
                end else begin
                    num_next = 17'(fl) - {1'b0, rel};
                end
            end
            ADV_DIV: begin
                num_next  = {num_reg[15:0], 1'b0};
                rem_next  = (rem_sh >= {1'b0, geo.range}) ? 16'(rem_sh - {1'b0, geo.range})
                                                          : rem_sh[15:0];
                step_next = step_reg + 5'd1;
            end
            ADV_DONE: begin
                if (geo.fwd) begin
                    base_next = cfg.loop_start + rem_reg;
                end else begin
                    base_next = (rem_reg == '0) ? cfg.loop_end : cfg.loop_start - rem_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ADV_IDLE;
            base_reg   <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
            step_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

endmodule

// File: sv/lsp_mix.sv
module lsp_mix import lsp_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [MIX_W-1:0]       in_mix_left,
    input  logic signed [MIX_W-1:0]       in_mix_right,
    input  logic [ADDR_W-1:0]             in_pos,
    input  logic                          in_playing,
    input  logic signed [SAMPLE_BITS-1:0] in_left,
    input  logic signed [SAMPLE_BITS-1:0] in_right,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [MIX_W-1:0]       m_mix_left_out,
    output logic signed [MIX_W-1:0]       m_mix_right_out,
    output logic [ADDR_W-1:0]             m_read_position,
    output logic                          m_playing
);

    localparam int PW   = SAMPLE_BITS + 17;
    localparam int RSH  = (SAMPLE_BITS >= 12) ? SAMPLE_BITS - 12 : 0;
    localparam int LSH  = (SAMPLE_BITS < 12) ? 12 - SAMPLE_BITS : 0;
    localparam int HALF = (RSH > 0) ? 2 ** (RSH - 1) : 0;
    localparam int EW   = PW + LSH + 2;

    logic                    va_reg;
    logic signed [PW-1:0]    pl_reg, pr_reg;
    logic signed [MIX_W-1:0] mla_reg, mra_reg;
    logic [ADDR_W-1:0]       posa_reg;
    logic                    playa_reg;

    logic                    mv_reg;
    logic signed [MIX_W-1:0] mlo_reg, mro_reg;
    logic [ADDR_W-1:0]       poso_reg;
    logic                    playo_reg;

    logic                    out_en;
    logic [15:0]             gain;
    logic signed [PW-1:0]    prod_l, prod_r;

    function automatic logic [15:0] gain_of(input logic [12:0] amt);
        logic [11:0] x;
        x = 12'(amt - UNITY_GAIN);
        // above unity the excess counts tenfold
        return (amt <= UNITY_GAIN) ? 16'(amt)
                                   : 16'(UNITY_GAIN) + {1'b0, x, 3'b0} + {3'b0, x, 1'b0};
    endfunction

    function automatic logic signed [MIX_W-1:0] scale_sum(input logic signed [PW-1:0] p,
                                                          input logic signed [MIX_W-1:0] mix);
        logic signed [EW-1:0] t;
        logic signed [EW-1:0] s;
        logic [EW-MIX_W:0]    hi;
        logic [MIX_W-1:0]     r;
        t  = ($signed(EW'(p)) + $signed(EW'(HALF))) >>> RSH;
        t  = t <<< LSH;
        s  = t + $signed(EW'(mix));
        hi = s[EW-1:MIX_W-1];
        if (&hi || ~|hi) begin
            r = s[MIX_W-1:0];
        end else begin
            r = s[EW-1] ? MIX_MIN : MIX_MAX;
        end
        return r;
    endfunction

    assign out_en   = !mv_reg || m_ready;
    assign in_ready = !va_reg || out_en;
    assign gain     = gain_of(cfg.amount);
    assign prod_l   = in_left * $signed({1'b0, gain});
    assign prod_r   = in_right * $signed({1'b0, gain});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                va_reg <= in_valid;
            end
            if (out_en) begin
                mv_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pl_reg    <= prod_l;
            pr_reg    <= prod_r;
            mla_reg   <= in_mix_left;
            mra_reg   <= in_mix_right;
            posa_reg  <= in_pos;
            playa_reg <= in_playing;
        end
        if (out_en && va_reg) begin
            mlo_reg   <= (playa_reg && cfg.left_enable) ? scale_sum(pl_reg, mla_reg) : mla_reg;
            mro_reg   <= (playa_reg && cfg.right_enable) ? scale_sum(pr_reg, mra_reg) : mra_reg;
            poso_reg  <= posa_reg;
            playo_reg <= playa_reg;
        end
    end

    assign m_valid         = mv_reg;
    assign m_mix_left_out  = mlo_reg;
    assign m_mix_right_out = mro_reg;
    assign m_read_position = poso_reg;
    assign m_playing       = playo_reg;

endmodule

// File: sv/lsp_checker.sv
module lsp_checker import lsp_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_req_type,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [MIX_W-1:0] m_mix_left_out,
    input logic signed [MIX_W-1:0] m_mix_right_out,
    input logic [ADDR_W-1:0]       m_read_position,
    input logic                    m_playing,
    input logic                    cfg_ready
);

    logic [2:0] pend_reg, pend_next;
    logic       tick_in, res_out;

    assign tick_in = s_valid && s_ready && (s_req_type == REQ_TICK);
    assign res_out = m_valid && m_ready;

    // ticks accepted whose result is not yet taken
    always_comb begin
        pend_next = pend_reg + 3'(tick_in) - 3'(res_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mix_left_out)
            && $stable(m_mix_right_out) && $stable(m_read_position) && $stable(m_playing))
        else $error("stalled result changed");

    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != '0)
        else $error("result without an outstanding tick");

    a_silent_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_playing |-> m_read_position == '0)
        else $error("position reported while not playing");

    a_advance_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_ready |-> !s_ready)
        else $error("input taken during base advance");

endmodule

bind loop_sample_player lsp_checker u_lsp_checker (.*);
